>>> rtl/agdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped decimal text formatter: shared package
// Types, character codes, register indexes and sequencer states used by the
// formatter modules.
// ----------------------------------------------------------------------------
package agdt_pkg;

   // Fixed field widths.
   localparam int AMOUNT_W   = 64;
   localparam int BIT_W      = 6;   // counts the 64 shift steps of the conversion
   localparam int CHAR_W     = 8;
   localparam int POS_W      = 5;   // digit positions and digit counts
   localparam int LEN_W      = 7;   // character counts
   localparam int LEAD_W     = 6;   // fill length, bounded by the width register
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   // Register indexes of the control port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECIMAL_ENABLE = 3'd0,
      CSR_DECIMAL_PLACES = 3'd1,
      CSR_DECIMAL_COMMA  = 3'd2,
      CSR_GROUP_SIZE     = 3'd3,
      CSR_MIN_WIDTH      = 3'd4,
      CSR_LEFT_JUSTIFY   = 3'd5,
      CSR_ZERO_FILL      = 3'd6
   } csr_index_type;

   // ASCII codes.
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PERIOD = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;

   // Formatting controls as held by the register block.
   typedef struct packed {
      logic        decimal_enable;
      logic [3:0]  decimal_places;
      logic        decimal_comma;
      logic [3:0]  group_size;
      logic [5:0]  min_width;
      logic        left_justify;
      logic        zero_fill;
   } fmt_cfg_type;

   // Status of the binary to BCD unit.
   typedef struct packed {
      logic done;
      logic overflow;
   } conv_status_type;

   // Formatter sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_COUNT,
      ST_SIZE,
      ST_PLAN,
      ST_SIGN_PRE,
      ST_LEAD,
      ST_SIGN_POST,
      ST_INT,
      ST_COMMA,
      ST_POINT,
      ST_FRAC,
      ST_TRAIL
   } fmt_state_type;

endpackage
`default_nettype wire

>>> rtl/agdt_bcd_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped decimal text formatter: binary to BCD unit
// Shift-and-add-3 conversion of the amount magnitude, one bit per cycle, into
// the low MAX_DIGITS decimal digits plus a sticky overflow flag.
// ----------------------------------------------------------------------------
module agdt_bcd_conv #(
   parameter int MAX_DIGITS = 19
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   load,
   input  wire logic [agdt_pkg::AMOUNT_W-1:0]          amount,
   output agdt_pkg::conv_status_type                   status,
   output logic      [MAX_DIGITS-1:0][3:0]             digits
);
   import agdt_pkg::*;

   localparam int BCD_W = MAX_DIGITS * 4;

   logic [AMOUNT_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [BCD_W-1:0]    adj;
   logic                ovf_ff, ovf_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;

   // Add three to every digit of five or more before the shift.
   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         adj[k*4 +: 4] = (bcd_ff[k*4 +: 4] >= 4'd5) ? bcd_ff[k*4 +: 4] + 4'd3
                                                     : bcd_ff[k*4 +: 4];
      end
   end

   // Load the magnitude, then shift one bit into the digits per cycle.
   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      ovf_in  = ovf_ff;
      run_in  = run_ff;
      bit_in  = bit_ff;
      done_in = 1'b0;
      if (load) begin
         mag_in = amount[AMOUNT_W-1] ? (~amount + AMOUNT_W'(1)) : amount;
         bcd_in = '0;
         ovf_in = 1'b0;
         run_in = 1'b1;
         bit_in = '0;
      end else if (run_ff) begin
         bcd_in = {adj[BCD_W-2:0], mag_ff[AMOUNT_W-1]};
         ovf_in = ovf_ff | adj[BCD_W-1];
         mag_in = {mag_ff[AMOUNT_W-2:0], 1'b0};
         bit_in = bit_ff + BIT_W'(1);
         if (bit_ff == BIT_W'(AMOUNT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         bit_ff  <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      ovf_ff <= ovf_in;
   end

   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;
   assign digits          = bcd_ff;

endmodule
`default_nettype wire

>>> rtl/agdt_fmt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped decimal text formatter: sequencer and character generator
// Finds the digit count, counts grouping commas, sizes the field and then
// sends the text one character per cycle.
// ----------------------------------------------------------------------------
module agdt_fmt #(
   parameter int MAX_DIGITS  = 19,
   parameter int FIELD_CHARS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                amount_sign,
   output logic                                     conv_start,
   input  agdt_pkg::conv_status_type                conv_status,
   input  wire logic [MAX_DIGITS-1:0][3:0]          digits,
   input  agdt_pkg::fmt_cfg_type                    cfg,
   output logic                                     rsp_strobe,
   output logic      [agdt_pkg::CHAR_W-1:0]         rsp_text_char,
   output logic                                     rsp_last_char
);
   import agdt_pkg::*;

   localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CHR_W = $clog2(FIELD_CHARS);

   fmt_state_type     state_ff, state_in;
   logic              neg_ff, neg_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  dcnt_ff, dcnt_in;
   logic [POS_W-1:0]  de_ff, de_in;
   logic [POS_W-1:0]  il_ff, il_in;
   logic [POS_W-1:0]  j_ff, j_in;
   logic [3:0]        grp_ff, grp_in;
   logic [POS_W-1:0]  comma_ff, comma_in;
   logic [CHR_W-1:0]  tm1_ff, tm1_in;
   logic [CHR_W-1:0]  cnt_ff, cnt_in;
   logic [LEAD_W-1:0] lead_ff, lead_in;
   logic              strobe_ff, strobe_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;

   logic [3:0]        raw_digit;
   logic [3:0]        cur_digit;
   logic [POS_W-1:0]  p_ext;
   logic [POS_W-1:0]  pe;
   logic [POS_W-1:0]  d_found;
   logic [POS_W-1:0]  de_calc;
   logic [LEN_W-1:0]  body_len;
   logic [LEN_W-1:0]  text_len;
   logic [LEN_W-1:0]  wid_len;
   logic [LEN_W-1:0]  total_len;
   logic [LEN_W-1:0]  cap_len;
   logic              pre_go;
   logic              lead_go;
   logic              post_go;
   logic              emit;
   fmt_state_type     after;

   // Digit read; positions at or above the digit count read as zero.
   assign raw_digit = digits[pos_ff[DIG_W-1:0]];
   assign cur_digit = (pos_ff < dcnt_ff) ? raw_digit : 4'd0;

   assign p_ext   = POS_W'(cfg.decimal_places);
   assign pe      = cfg.decimal_enable ? p_ext : '0;
   assign d_found = pos_ff + POS_W'(1);
   assign de_calc = (cfg.decimal_enable && (d_found <= p_ext)) ? p_ext + POS_W'(1)
                                                               : d_found;

   // Field sizing from the body length, sign and minimum width.
   assign body_len  = LEN_W'(de_ff) + LEN_W'(cfg.decimal_enable) + LEN_W'(comma_ff);
   assign text_len  = body_len + LEN_W'(neg_ff);
   assign wid_len   = LEN_W'(cfg.min_width);
   assign total_len = (wid_len > text_len) ? wid_len : text_len;
   assign cap_len   = (total_len > LEN_W'(FIELD_CHARS)) ? LEN_W'(FIELD_CHARS) : total_len;

   assign pre_go  = neg_ff && cfg.zero_fill;
   assign lead_go = !cfg.left_justify && (lead_ff != '0);
   assign post_go = neg_ff && !cfg.zero_fill;

   // Next state and outputs.
   always_comb begin
      state_in   = state_ff;
      neg_in     = neg_ff;
      pos_in     = pos_ff;
      dcnt_in    = dcnt_ff;
      de_in      = de_ff;
      il_in      = il_ff;
      j_in       = j_ff;
      grp_in     = grp_ff;
      comma_in   = comma_ff;
      tm1_in     = tm1_ff;
      cnt_in     = cnt_ff;
      lead_in    = lead_ff;
      conv_start = 1'b0;
      emit       = 1'b0;
      char_in    = char_ff;
      after      = ST_IDLE;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               conv_start = 1'b1;
               neg_in     = amount_sign;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_status.done) begin
               pos_in   = POS_W'(MAX_DIGITS - 1);
               state_in = ST_SCAN;
            end
         end
         // Walk down from the top to the highest nonzero digit or digit 0.
         ST_SCAN: begin
            if (conv_status.overflow || (raw_digit != 4'd0) || (pos_ff == '0)) begin
               dcnt_in  = d_found;
               de_in    = de_calc;
               il_in    = de_calc - pe;
               j_in     = '0;
               grp_in   = '0;
               comma_in = '0;
               state_in = ST_COUNT;
            end else begin
               pos_in = pos_ff - POS_W'(1);
            end
         end
         // Count grouping commas over the integer digits.
         ST_COUNT: begin
            if ((cfg.group_size == 4'd0) || (j_ff == il_ff - POS_W'(1))) begin
               state_in = ST_SIZE;
            end else begin
               j_in = j_ff + POS_W'(1);
               if (grp_ff == cfg.group_size - 4'd1) begin
                  grp_in   = '0;
                  comma_in = comma_ff + POS_W'(1);
               end else begin
                  grp_in = grp_ff + 4'd1;
               end
            end
         end
         ST_SIZE: begin
            lead_in  = (wid_len > text_len) ? LEAD_W'(wid_len - text_len) : '0;
            tm1_in   = CHR_W'(cap_len - LEN_W'(1));
            cnt_in   = '0;
            pos_in   = de_ff - POS_W'(1);
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            state_in = pre_go ? ST_SIGN_PRE : lead_go ? ST_LEAD :
                       post_go ? ST_SIGN_POST : ST_INT;
         end
         ST_SIGN_PRE: begin
            emit    = 1'b1;
            char_in = CHAR_MINUS;
            after   = lead_go ? ST_LEAD : post_go ? ST_SIGN_POST : ST_INT;
         end
         ST_LEAD: begin
            emit    = 1'b1;
            char_in = cfg.zero_fill ? CHAR_ZERO : CHAR_SPACE;
            lead_in = lead_ff - LEAD_W'(1);
            if (lead_ff == LEAD_W'(1)) begin
               after = post_go ? ST_SIGN_POST : ST_INT;
            end else begin
               after = ST_LEAD;
            end
         end
         ST_SIGN_POST: begin
            emit    = 1'b1;
            char_in = CHAR_MINUS;
            after   = ST_INT;
         end
         // Integer digits, with a comma after each full group.
         ST_INT: begin
            emit    = 1'b1;
            char_in = CHAR_ZERO + CHAR_W'(cur_digit);
            pos_in  = pos_ff - POS_W'(1);
            if (pos_ff == pe) begin
               after = cfg.decimal_enable ? ST_POINT : ST_TRAIL;
            end else if ((cfg.group_size != 4'd0) && (grp_ff == 4'd0)) begin
               grp_in = cfg.group_size - 4'd1;
               after  = ST_COMMA;
            end else begin
               if (cfg.group_size != 4'd0) begin
                  grp_in = grp_ff - 4'd1;
               end
               after = ST_INT;
            end
         end
         ST_COMMA: begin
            emit    = 1'b1;
            char_in = CHAR_COMMA;
            after   = ST_INT;
         end
         ST_POINT: begin
            emit    = 1'b1;
            char_in = cfg.decimal_comma ? CHAR_COMMA : CHAR_PERIOD;
            after   = (cfg.decimal_places != 4'd0) ? ST_FRAC : ST_TRAIL;
         end
         ST_FRAC: begin
            emit    = 1'b1;
            char_in = CHAR_ZERO + CHAR_W'(cur_digit);
            pos_in  = pos_ff - POS_W'(1);
            after   = (pos_ff == '0) ? ST_TRAIL : ST_FRAC;
         end
         ST_TRAIL: begin
            emit    = 1'b1;
            char_in = CHAR_SPACE;
            lead_in = lead_ff - LEAD_W'(1);
            after   = ST_TRAIL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Character bookkeeping; the last character of the field ends the item.
      strobe_in = emit;
      last_in   = emit && (cnt_ff == tm1_ff);
      if (emit) begin
         if (cnt_ff == tm1_ff) begin
            state_in = ST_IDLE;
         end else begin
            cnt_in   = cnt_ff + CHR_W'(1);
            state_in = after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      pos_ff   <= pos_in;
      dcnt_ff  <= dcnt_in;
      de_ff    <= de_in;
      il_ff    <= il_in;
      j_ff     <= j_in;
      grp_ff   <= grp_in;
      comma_ff <= comma_in;
      tm1_ff   <= tm1_in;
      cnt_ff   <= cnt_in;
      lead_ff  <= lead_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule
`default_nettype wire

>>> rtl/amount_to_grouped_decimal_text.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped decimal amount formatter
// Turns a signed 64-bit amount into its decimal text with optional decimal
// point, digit grouping, sign and field padding, one character per strobe.
// ----------------------------------------------------------------------------
// An amount is taken when start is high and busy is low. Busy then stays high
// until the last character is on the result ports, and a new amount may be
// taken in that same cycle. Characters appear on rsp_text_char for one cycle
// each, marked by rsp_strobe, with rsp_last_char on the final one; the receiver
// must take every transfer as it comes. Each amount first goes through the
// 64-step bit-serial binary to BCD conversion. The search for the leading
// digit and the count of the grouping commas follow, and then the text, one
// character per strobe and at most FIELD_CHARS characters long.
// Control registers are written through csr_we, csr_index and csr_wdata and
// must only change while busy is low.
// ----------------------------------------------------------------------------
module amount_to_grouped_decimal_text #(
   parameter int MAX_DIGITS  = 19,
   parameter int FIELD_CHARS = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [agdt_pkg::AMOUNT_W-1:0]        req_amount,
   output logic                                      rsp_strobe,
   output logic      [agdt_pkg::CHAR_W-1:0]          rsp_text_char,
   output logic                                      rsp_last_char,
   input  wire logic                                 csr_we,
   input  wire logic [agdt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [agdt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import agdt_pkg::*;

   logic       decimal_enable_ff;
   logic [3:0] decimal_places_ff;
   logic       decimal_comma_ff;
   logic [3:0] group_size_ff;
   logic [5:0] min_width_ff;
   logic       left_justify_ff;
   logic       zero_fill_ff;

   fmt_cfg_type                    cfg;
   conv_status_type                conv_status;
   logic                           conv_start;
   logic [MAX_DIGITS-1:0][3:0]     digits;

   // Control register writes; unused indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         decimal_enable_ff <= 1'b0;
         decimal_places_ff <= 4'd2;
         decimal_comma_ff  <= 1'b0;
         group_size_ff     <= 4'd0;
         min_width_ff      <= 6'd0;
         left_justify_ff   <= 1'b0;
         zero_fill_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DECIMAL_ENABLE: decimal_enable_ff <= csr_wdata[0];
            CSR_DECIMAL_PLACES: decimal_places_ff <= csr_wdata[3:0];
            CSR_DECIMAL_COMMA:  decimal_comma_ff  <= csr_wdata[0];
            CSR_GROUP_SIZE:     group_size_ff     <= csr_wdata[3:0];
            CSR_MIN_WIDTH:      min_width_ff      <= csr_wdata[5:0];
            CSR_LEFT_JUSTIFY:   left_justify_ff   <= csr_wdata[0];
            CSR_ZERO_FILL:      zero_fill_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.decimal_enable = decimal_enable_ff;
   assign cfg.decimal_places = decimal_places_ff;
   assign cfg.decimal_comma  = decimal_comma_ff;
   assign cfg.group_size     = group_size_ff;
   assign cfg.min_width      = min_width_ff;
   assign cfg.left_justify   = left_justify_ff;
   assign cfg.zero_fill      = zero_fill_ff;

   // Binary to BCD conversion of the magnitude.
   agdt_bcd_conv #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_conv (
      .clock  (clock),
      .reset  (reset),
      .load   (conv_start),
      .amount (req_amount),
      .status (conv_status),
      .digits (digits)
   );

   // Sequencer and character output.
   agdt_fmt #(
      .MAX_DIGITS  (MAX_DIGITS),
      .FIELD_CHARS (FIELD_CHARS)
   ) u_fmt (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .amount_sign   (req_amount[AMOUNT_W-1]),
      .conv_start    (conv_start),
      .conv_status   (conv_status),
      .digits        (digits),
      .cfg           (cfg),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
`default_nettype wire

>>> bench/amount_to_grouped_decimal_text_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grouped decimal amount formatter: testbench
// Sends signed 64-bit amounts under a series of formatting setups, predicts
// the text of each amount character by character, and checks every character
// and its end-of-text flag as the block emits it. Directed tests cover the
// reset setup, the decimal point, grouping, padding and an ignored register
// write. Random phases with random and extreme setups follow.
// ----------------------------------------------------------------------------
module amount_to_grouped_decimal_text_tb;
   import agdt_pkg::*;

   localparam int MAX_DIGITS  = 19;
   localparam int FIELD_CHARS = 64;
   localparam int WORK_CHARS  = 128;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_COUNT = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [AMOUNT_W-1:0] AMOUNT_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [AMOUNT_W-1:0]   req_amount = '0;
   logic                  rsp_strobe;
   logic [CHAR_W-1:0]     rsp_text_char;
   logic                  rsp_last_char;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   fmt_cfg_type   current_format;
   text_char_type expected_chars[$];
   int            error_count = 0;
   int            stall_cycles = 0;
   bit            sender_gaps = 1'b1;

   amount_to_grouped_decimal_text dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_amount    (req_amount),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Works out the text of one amount under the current setup and queues
   // its characters.
   function automatic void format_amount_text(input logic [AMOUNT_W-1:0] amount);
      logic [AMOUNT_W-1:0] magnitude;
      logic [3:0]          digits[MAX_DIGITS];
      logic [CHAR_W-1:0]   body[WORK_CHARS];
      logic [CHAR_W-1:0]   line[WORK_CHARS];
      logic [CHAR_W-1:0]   point_char;
      logic [CHAR_W-1:0]   fill_char;
      logic                negative;
      int                  ndig;
      int                  nbody;
      int                  npos;
      int                  group_pos;
      int                  lead;
      int                  total;
      text_char_type       ch;
      negative   = amount[AMOUNT_W-1];
      magnitude  = negative ? (~amount + 64'd1) : amount;
      point_char = current_format.decimal_comma ? CHAR_COMMA : CHAR_PERIOD;
      fill_char  = current_format.zero_fill ? CHAR_ZERO : CHAR_SPACE;

      // Decimal digits, least significant first.
      ndig = 0;
      do begin
         digits[ndig] = 4'(magnitude % 64'd10);
         ndig++;
         magnitude = magnitude / 64'd10;
      end while (magnitude != 0 && ndig < MAX_DIGITS);

      // The body is built from its right end: fraction, point, grouped digits.
      nbody = 0;
      group_pos = current_format.decimal_enable ? -int'(current_format.decimal_places) : 0;
      for (int i = 0; i < ndig; i++) begin
         if (current_format.decimal_enable && nbody == int'(current_format.decimal_places)) begin
            body[nbody] = point_char;
            nbody++;
         end
         if (current_format.group_size != 0) begin
            if (group_pos == int'(current_format.group_size)) begin
               body[nbody] = CHAR_COMMA;
               nbody++;
               group_pos = 1;
            end else begin
               group_pos++;
            end
         end
         body[nbody] = CHAR_ZERO + digits[i];
         nbody++;
      end

      // Short values are padded out to the 0.00 form.
      if (current_format.decimal_enable && nbody <= int'(current_format.decimal_places)) begin
         while (nbody < int'(current_format.decimal_places)) begin
            body[nbody] = CHAR_ZERO;
            nbody++;
         end
         body[nbody] = point_char;
         body[nbody + 1] = CHAR_ZERO;
         nbody += 2;
      end

      lead = 0;
      if (current_format.min_width != 0)
         lead = int'(current_format.min_width) - nbody - int'(negative);

      // Sign and fill around the body.
      npos = 0;
      if (negative && current_format.zero_fill) begin
         line[npos] = CHAR_MINUS;
         npos++;
      end
      if (!current_format.left_justify) begin
         for (int i = 0; i < lead; i++) begin
            line[npos] = fill_char;
            npos++;
         end
      end
      if (negative && !current_format.zero_fill) begin
         line[npos] = CHAR_MINUS;
         npos++;
      end
      for (int i = nbody; i > 0; i--) begin
         line[npos] = body[i - 1];
         npos++;
      end
      if (current_format.left_justify) begin
         for (int i = 0; i < lead; i++) begin
            line[npos] = CHAR_SPACE;
            npos++;
         end
      end

      total = (npos < FIELD_CHARS) ? npos : FIELD_CHARS;
      for (int i = 0; i < total; i++) begin
         ch.code = line[i];
         ch.last = (i == total - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // Sends one amount, after a random gap when sender_gaps is set, and queues
   // its text once the transfer is taken. Start is left high so a following
   // amount can go out back to back.
   task automatic send_amount(input logic [AMOUNT_W-1:0] amount);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_amount <= amount;
      do @(posedge clock); while (busy);
      format_amount_text(amount);
   endtask

   // Drops start and waits until all text has come and the block is idle.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0 || busy);
   endtask

   // One register write; the setup copy follows the write as it lands.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_DECIMAL_ENABLE: current_format.decimal_enable = data[0];
         CSR_DECIMAL_PLACES: current_format.decimal_places = data[3:0];
         CSR_DECIMAL_COMMA:  current_format.decimal_comma  = data[0];
         CSR_GROUP_SIZE:     current_format.group_size     = data[3:0];
         CSR_MIN_WIDTH:      current_format.min_width      = data[5:0];
         CSR_LEFT_JUSTIFY:   current_format.left_justify   = data[0];
         CSR_ZERO_FILL:      current_format.zero_fill      = data[0];
         default: ;
      endcase
   endtask

   // Loads a whole setup once the block is idle. Unused upper data bits
   // carry random noise.
   task automatic apply_format(input fmt_cfg_type f);
      logic [CSR_DATA_W-1:0] noise;
      wait_idle();
      noise = CSR_DATA_W'($urandom);
      write_reg(CSR_DECIMAL_ENABLE, {noise[5:1], f.decimal_enable});
      write_reg(CSR_DECIMAL_PLACES, {noise[5:4], f.decimal_places});
      write_reg(CSR_DECIMAL_COMMA,  {noise[4:0], f.decimal_comma});
      write_reg(CSR_GROUP_SIZE,     {noise[1:0], f.group_size});
      write_reg(CSR_MIN_WIDTH,      f.min_width);
      write_reg(CSR_LEFT_JUSTIFY,   {noise[3:0], noise[5], f.left_justify});
      write_reg(CSR_ZERO_FILL,      {noise[0], noise[5:2], f.zero_fill});
      csr_we <= 1'b0;
   endtask

   function automatic fmt_cfg_type make_format(input logic en, input logic [3:0] places,
                                               input logic comma, input logic [3:0] group,
                                               input logic [5:0] width, input logic left,
                                               input logic zero);
      fmt_cfg_type f;
      f.decimal_enable = en;
      f.decimal_places = places;
      f.decimal_comma  = comma;
      f.group_size     = group;
      f.min_width      = width;
      f.left_justify   = left;
      f.zero_fill      = zero;
      return f;
   endfunction

   function automatic fmt_cfg_type random_format();
      fmt_cfg_type f;
      f.decimal_enable = 1'($urandom_range(0, 1));
      f.decimal_places = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(0, 4));
      f.decimal_comma  = 1'($urandom_range(0, 1));
      f.group_size     = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      f.min_width      = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, 24));
      f.left_justify   = 1'($urandom_range(0, 1));
      f.zero_fill      = 1'($urandom_range(0, 1));
      return f;
   endfunction

   // Amounts of every size: full range, a chosen digit count, small values
   // and the edges of the range.
   function automatic logic [AMOUNT_W-1:0] random_amount();
      logic [AMOUNT_W-1:0] value;
      logic [AMOUNT_W-1:0] scale;
      int                  digits_wanted;
      value = '0;
      case ($urandom_range(0, 4))
         0: value = {$urandom, $urandom};
         1: begin
            digits_wanted = $urandom_range(1, 19);
            scale = 64'd1;
            repeat (digits_wanted) scale = scale * 64'd10;
            value = {$urandom, $urandom} % scale;
            if ($urandom_range(0, 1)) value = -value;
         end
         2: begin
            value = 64'($urandom_range(0, 999));
            if ($urandom_range(0, 1)) value = -value;
         end
         default: begin
            case ($urandom_range(0, 5))
               0: value = AMOUNT_MAX;
               1: value = AMOUNT_MIN;
               2: value = AMOUNT_MIN + 64'd1;
               3: value = '0;
               4: value = '1;
               default: value = 64'd1;
            endcase
         end
      endcase
      return value;
   endfunction

   // Reset setup: plain integers, no padding.
   task automatic test_default_format();
      send_amount('0);
      send_amount('1);
      send_amount(AMOUNT_MAX);
      send_amount(AMOUNT_MIN);
   endtask

   // Decimal point placement, padding to the 0.00 form, comma as point.
   task automatic test_decimal_point();
      apply_format(make_format(1'b1, 4'd2, 1'b0, 4'd0, 6'd0, 1'b0, 1'b0));
      send_amount(64'd5);
      send_amount(-64'd123);
      send_amount(64'd100);
      apply_format(make_format(1'b1, 4'd0, 1'b1, 4'd0, 6'd0, 1'b0, 1'b0));
      send_amount(64'd123);
      apply_format(make_format(1'b1, 4'd15, 1'b0, 4'd0, 6'd0, 1'b0, 1'b0));
      send_amount(64'd7);
   endtask

   // Grouping commas counted from the point or from the right end.
   task automatic test_grouping();
      apply_format(make_format(1'b1, 4'd2, 1'b0, 4'd3, 6'd0, 1'b0, 1'b0));
      send_amount(64'd123456789);
      send_amount(AMOUNT_MIN);
      apply_format(make_format(1'b0, 4'd2, 1'b0, 4'd1, 6'd0, 1'b0, 1'b0));
      send_amount(AMOUNT_MAX);
      apply_format(make_format(1'b1, 4'd1, 1'b1, 4'd15, 6'd0, 1'b0, 1'b0));
      send_amount(AMOUNT_MIN + 64'd1);
   endtask

   // Field width with zero or space fill, sign placement and left justify.
   task automatic test_padding();
      apply_format(make_format(1'b1, 4'd2, 1'b0, 4'd3, 6'd12, 1'b0, 1'b1));
      send_amount(-64'd4567);
      apply_format(make_format(1'b1, 4'd2, 1'b0, 4'd3, 6'd12, 1'b0, 1'b0));
      send_amount(-64'd4567);
      apply_format(make_format(1'b1, 4'd2, 1'b0, 4'd3, 6'd12, 1'b1, 1'b1));
      send_amount(-64'd4567);
      apply_format(make_format(1'b0, 4'd2, 1'b0, 4'd0, 6'd3, 1'b0, 1'b1));
      send_amount(64'd123456);
      apply_format(make_format(1'b0, 4'd2, 1'b0, 4'd0, 6'd63, 1'b1, 1'b0));
      send_amount(64'd1);
   endtask

   // A write to an index with no register must leave the setup unchanged.
   task automatic test_register_index();
      wait_idle();
      write_reg(CSR_UNUSED_INDEX, '1);
      csr_we <= 1'b0;
      send_amount(-64'd42);
   endtask

   // Random phases: extreme setups first, then random ones.
   task automatic test_random_amounts();
      fmt_cfg_type f;
      int          items;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0)
            f = make_format(1'b1, 4'd15, 1'b1, 4'd15, 6'd63, 1'b1, 1'b1);
         else if (phase == 1)
            f = make_format(1'b0, 4'd0, 1'b0, 4'd0, 6'd0, 1'b0, 1'b0);
         else
            f = random_format();
         apply_format(f);
         sender_gaps = ($urandom_range(0, 2) != 0);
         items = $urandom_range(17, 21);
         for (int i = 0; i < items; i++) begin
            // Once, midway through phase 3, hold off until all queued text is out.
            if (phase == 3 && i == items / 2)
               wait_idle();
            send_amount(random_amount());
         end
      end
   endtask

   // Each character transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_strobe) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                      rsp_text_char, rsp_last_char));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_text_char !== want.code)
               report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                         rsp_text_char, want.code));
            if (rsp_last_char !== want.last)
               report_mismatch($sformatf("last_char %0b, expected %0b on char 0x%02h",
                                         rsp_last_char, want.last, want.code));
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      current_format = make_format(1'b0, 4'd2, 1'b0, 4'd0, 6'd0, 1'b0, 1'b0);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_format();
      test_decimal_point();
      test_grouping();
      test_padding();
      test_register_index();
      test_random_amounts();

      // Let the last text drain, then watch for stray characters.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
